@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hdl/ascp_pkg.sv @@
// shared constants, types and codes of the scope trace renderer
package ascp_pkg;

  localparam int SAMPLE_COUNT = 128;
  localparam int ADDR_W       = $clog2(SAMPLE_COUNT);
  localparam int SAMPLE_W     = 16;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 4;
  localparam int CFG_W        = 11;
  localparam int PEAK_W       = 16;
  localparam int FRAC_W       = 8;
  localparam int GAIN_W       = 10;

  localparam int MID_ROW      = 8;
  localparam int ROW_MIN      = 2;
  localparam int ROW_MAX      = 13;
  localparam int GAIN_LIMIT   = 110;
  localparam int GAIN_NUM     = 11000;
  localparam int GAIN_FLAT    = 100;
  localparam int GAIN_CAP     = 620;
  localparam int FULL_SCALE   = 10000;
  localparam int QMAX         = 7;
  localparam int QCNT_W       = 3;

  localparam int WIDTH_RESET  = 240;
  localparam int WIDTH_MIN    = 2;
  localparam int WIDTH_MAX    = 1024;

  localparam int DIV_DVD_W    = ADDR_W + FRAC_W + COL_W;
  localparam int DIV_DVS_W    = COL_W;
  localparam int ITER_W       = $clog2(DIV_DVD_W + 1);
  localparam int GAIN_ITERS   = 14;
  localparam int GAIN_SHIFT   = DIV_DVD_W - GAIN_ITERS;

  localparam int DIFF_W       = SAMPLE_W + 1;
  localparam int MPROD_W      = DIFF_W + FRAC_W + 1;
  localparam int SMOOTH_W     = SAMPLE_W + 1;
  localparam int SUM_W        = SAMPLE_W + 2;
  localparam int PROD_W       = SMOOTH_W + GAIN_W + 1;
  localparam int ACC_W        = PROD_W + 3;

  typedef enum logic {
    FUNC_STORE = 1'b0,
    FUNC_DRAW  = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_GAIN_WAIT,
    ST_POS,
    ST_POS_WAIT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_INTERP,
    ST_SCALE,
    ST_SCALE6,
    ST_QUOT,
    ST_ROW
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
    logic [ITER_W-1:0]    iters;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [ROW_W-1:0] bottom_row;
    logic [ROW_W-1:0] top_row;
    logic [COL_W-1:0] column;
  } result_t;

endpackage

@@ hdl/autogain_scope_trace_renderer_core.sv @@
// top level of the auto-gain scope trace renderer
//
//   channel  dir   handshake               payload
//   in_      in    in_tvalid / in_tready   tdata: index, sample; tuser: func
//   out_     out   out_tvalid / out_tready tdata: column, top_row, bottom_row
//   cfg_     in    cfg_valid / cfg_ready   cfg_data: screen_width
//
// a store request leaves the engine idle; a draw request holds the input through the
// column position divide, the gain divide when the peak is below 110, the subtract
// loop that scales the row and the fixed read, interpolate, scale and row states
// rst_n is synchronous: peak returns to 1, previous row to 8, width to 240
// a finished span waits in the output register; the engine holds while it is full and not being read
module autogain_scope_trace_renderer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [9:0] index, [25:10] sample
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] column, [13:10] top_row, [17:14] bottom_row
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data    // screen_width
);
  import ascp_pkg::*;

`include "assert_macros.svh"

  logic [CFG_W-1:0] width_r, width_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r, out_res_nxt;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  ascp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ascp_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (in_tvalid),
    .item_ready   (in_tready),
    .item_func    (func_t'(in_tuser)),
    .item_index   (in_tdata[COL_W-1:0]),
    .item_sample  (in_tdata[COL_W +: SAMPLE_W]),
    .screen_width (width_r),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  always_comb begin
    cfg_ready     = 1'b1;
    width_nxt     = (cfg_valid && cfg_ready) ? cfg_data : width_r;
    res_ready     = !out_valid_r || out_tready;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CFG_W'(WIDTH_RESET);
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r};

  `ASSERT_IMPLIES(a_row_order, clk, rst_n, out_tvalid, out_tdata[13:10] <= out_tdata[17:14])
  `ASSERT_IMPLIES(a_top_floor, clk, rst_n, out_tvalid, out_tdata[13:10] >= ROW_MIN)
  `ASSERT_IMPLIES(a_bottom_ceiling, clk, rst_n, out_tvalid, out_tdata[17:14] <= ROW_MAX)
  `ASSERT_IMPLIES(a_busy_in_divide, clk, rst_n, div_rsp.done, !in_tready)
  `ASSERT_NEXT(a_store_one_cycle, clk, rst_n, in_tvalid && in_tready && !in_tuser, in_tready)

endmodule

@@ hdl/ascp_div.sv @@
// shared restoring divider, one quotient bit per cycle
module ascp_div (
  input  logic             clk,
  input  logic             rst_n,
  input  ascp_pkg::div_req_t req,
  output ascp_pkg::div_rsp_t rsp
);
  import ascp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [ITER_W-1:0]    cnt_r, cnt_nxt;
  logic [DIV_DVD_W-1:0] dq_r, dq_nxt;
  logic [DIV_DVS_W-1:0] rem_r, rem_nxt;
  logic [DIV_DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_DVS_W:0]   shifted;
  logic                 fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r, dq_r[DIV_DVD_W-1]};
    fits     = shifted >= {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = DIV_DVS_W'(shifted - {1'b0, dvs_r});
      end else begin
        rem_nxt = shifted[DIV_DVS_W-1:0];
      end
      dq_nxt  = {dq_r[DIV_DVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = dq_r;

endmodule

@@ hdl/ascp_engine.sv @@
// sequencer, sample store and datapath of the trace renderer
module ascp_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  ascp_pkg::func_t                     item_func,
  input  logic [ascp_pkg::COL_W-1:0]          item_index,
  input  logic signed [ascp_pkg::SAMPLE_W-1:0] item_sample,
  input  logic [ascp_pkg::CFG_W-1:0]          screen_width,
  output ascp_pkg::div_req_t                  div_req,
  input  ascp_pkg::div_rsp_t                  div_rsp,
  output logic                                res_valid,
  input  logic                                res_ready,
  output ascp_pkg::result_t                   res
);
  import ascp_pkg::*;

  state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] mem [SAMPLE_COUNT];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       mem_we;

  logic [PEAK_W-1:0]          peak_r, peak_nxt;
  logic [ROW_W-1:0]           prev_r, prev_nxt;
  logic [COL_W-1:0]           col_r, col_nxt;
  logic [DIV_DVS_W-1:0]       wm1_r, wm1_nxt;
  logic [GAIN_W-1:0]          gain_r, gain_nxt;
  logic [ADDR_W-1:0]          si_r, si_nxt;
  logic [ADDR_W-1:0]          ni_r, ni_nxt;
  logic [FRAC_W-1:0]          frac_r, frac_nxt;
  logic signed [SAMPLE_W-1:0] s0_r, s0_nxt;
  logic signed [MPROD_W-1:0]  mprod_r, mprod_nxt;
  logic signed [SMOOTH_W-1:0] smooth_r, smooth_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic                       neg_r, neg_nxt;
  logic [QCNT_W-1:0]          cnt_r, cnt_nxt;

  logic                       accept;
  logic [CFG_W-1:0]           w_cl;
  logic                       col_ok;
  logic signed [SAMPLE_W:0]   sample_ext;
  logic [SAMPLE_W:0]          mag_ext;
  logic [PEAK_W-1:0]          mag;
  logic [PEAK_W-1:0]          peak_base;
  logic [DIV_DVD_W-1:0]       pos_num;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [MPROD_W-1:0]  mprod_adj;
  logic signed [MPROD_W-1:0]  mprod_sh;
  logic signed [SUM_W-1:0]    smooth_sum;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    prod6;
  logic [ROW_W:0]             wave_raw;
  logic [ROW_W-1:0]           wave;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[item_index[ADDR_W-1:0]] <= item_sample;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    item_ready = (state_r == ST_IDLE);
    accept     = item_valid && item_ready;

    if (screen_width < CFG_W'(WIDTH_MIN)) begin
      w_cl = CFG_W'(WIDTH_MIN);
    end else if (screen_width > CFG_W'(WIDTH_MAX)) begin
      w_cl = CFG_W'(WIDTH_MAX);
    end else begin
      w_cl = screen_width;
    end
    col_ok = {1'b0, item_index} < w_cl;

    sample_ext = {item_sample[SAMPLE_W-1], item_sample};
    mag_ext    = sample_ext[SAMPLE_W] ? (~sample_ext + 1'b1) : sample_ext;
    mag        = mag_ext[PEAK_W-1:0];
    peak_base  = (item_index == '0) ? PEAK_W'(1) : peak_r;
    mem_we     = accept && (item_func == FUNC_STORE)
                 && (item_index < COL_W'(SAMPLE_COUNT));

    pos_num  = (DIV_DVD_W'({col_r, {ADDR_W{1'b0}}}) - DIV_DVD_W'(col_r)) << FRAC_W;
    rd_addr  = (state_r == ST_RD1) ? ni_r : si_r;

    diff       = {rd_data_r[SAMPLE_W-1], rd_data_r} - {s0_r[SAMPLE_W-1], s0_r};
    mprod_adj  = mprod_r + (mprod_r[MPROD_W-1] ? MPROD_W'(255) : MPROD_W'(0));
    mprod_sh   = mprod_adj >>> FRAC_W;
    smooth_sum = {{2{s0_r[SAMPLE_W-1]}}, s0_r} + mprod_sh[SUM_W-1:0];
    prod_ext   = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    prod6      = (prod_ext <<< 2) + (prod_ext <<< 1);

    wave_raw = neg_r ? (ROW_W+1)'(MID_ROW) + (ROW_W+1)'(cnt_r)
                     : (ROW_W+1)'(MID_ROW) - (ROW_W+1)'(cnt_r);
    if (wave_raw < (ROW_W+1)'(ROW_MIN)) begin
      wave = ROW_W'(ROW_MIN);
    end else if (wave_raw > (ROW_W+1)'(ROW_MAX)) begin
      wave = ROW_W'(ROW_MAX);
    end else begin
      wave = wave_raw[ROW_W-1:0];
    end

    res.column     = col_r;
    res.top_row    = (wave < prev_r) ? wave : prev_r;
    res.bottom_row = (wave > prev_r) ? wave : prev_r;
    res_valid      = (state_r == ST_ROW);

    div_req    = '0;
    state_nxt  = state_r;
    peak_nxt   = peak_r;
    prev_nxt   = prev_r;
    col_nxt    = col_r;
    wm1_nxt    = wm1_r;
    gain_nxt   = gain_r;
    si_nxt     = si_r;
    ni_nxt     = ni_r;
    frac_nxt   = frac_r;
    s0_nxt     = s0_r;
    mprod_nxt  = mprod_r;
    smooth_nxt = smooth_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (item_func == FUNC_STORE) begin
            if (mem_we) begin
              peak_nxt = (mag > peak_base) ? mag : peak_base;
            end
          end else if (col_ok) begin
            col_nxt = item_index;
            wm1_nxt = DIV_DVS_W'(w_cl - 1'b1);
            if (item_index == '0) begin
              prev_nxt = ROW_W'(MID_ROW);
            end
            state_nxt = ST_GAIN;
          end
        end
      end
      ST_GAIN: begin
        if (peak_r < PEAK_W'(GAIN_LIMIT)) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_DVD_W'(GAIN_NUM) << GAIN_SHIFT;
          div_req.divisor  = peak_r[DIV_DVS_W-1:0];
          div_req.iters    = ITER_W'(GAIN_ITERS);
          state_nxt        = ST_GAIN_WAIT;
        end else begin
          gain_nxt  = GAIN_W'(GAIN_FLAT);
          state_nxt = ST_POS;
        end
      end
      ST_GAIN_WAIT: begin
        if (div_rsp.done) begin
          gain_nxt  = (div_rsp.quot > DIV_DVD_W'(GAIN_CAP)) ? GAIN_W'(GAIN_CAP)
                                                           : div_rsp.quot[GAIN_W-1:0];
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        div_req.start    = 1'b1;
        div_req.dividend = pos_num;
        div_req.divisor  = wm1_r;
        div_req.iters    = ITER_W'(DIV_DVD_W);
        state_nxt        = ST_POS_WAIT;
      end
      ST_POS_WAIT: begin
        if (div_rsp.done) begin
          si_nxt    = div_rsp.quot[FRAC_W +: ADDR_W];
          frac_nxt  = div_rsp.quot[FRAC_W-1:0];
          ni_nxt    = (div_rsp.quot[FRAC_W +: ADDR_W] == ADDR_W'(SAMPLE_COUNT - 1))
                      ? ADDR_W'(SAMPLE_COUNT - 1)
                      : div_rsp.quot[FRAC_W +: ADDR_W] + 1'b1;
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        s0_nxt    = rd_data_r;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        mprod_nxt = diff * $signed({1'b0, frac_r});
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        smooth_nxt = smooth_sum[SMOOTH_W-1:0];
        state_nxt  = ST_SCALE;
      end
      ST_SCALE: begin
        prod_nxt  = smooth_r * $signed({1'b0, gain_r});
        state_nxt = ST_SCALE6;
      end
      ST_SCALE6: begin
        neg_nxt   = prod6[ACC_W-1];
        acc_nxt   = prod6[ACC_W-1] ? (~prod6 + 1'b1) : prod6;
        cnt_nxt   = '0;
        state_nxt = ST_QUOT;
      end
      ST_QUOT: begin
        if (acc_r >= ACC_W'(FULL_SCALE) && cnt_r != QCNT_W'(QMAX)) begin
          acc_nxt = acc_r - ACC_W'(FULL_SCALE);
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        if (res_ready) begin
          prev_nxt  = wave;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      peak_r  <= PEAK_W'(1);
      prev_r  <= ROW_W'(MID_ROW);
    end else begin
      state_r <= state_nxt;
      peak_r  <= peak_nxt;
      prev_r  <= prev_nxt;
    end
    col_r    <= col_nxt;
    wm1_r    <= wm1_nxt;
    gain_r   <= gain_nxt;
    si_r     <= si_nxt;
    ni_r     <= ni_nxt;
    frac_r   <= frac_nxt;
    s0_r     <= s0_nxt;
    mprod_r  <= mprod_nxt;
    smooth_r <= smooth_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

@@ tb/autogain_scope_trace_renderer_core_tb.sv @@
// self-checking testbench of the auto-gain scope trace renderer core
`timescale 1ns / 100ps

module autogain_scope_trace_renderer_core_tb;
  import ascp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int REQ_TARGET  = 1050;
  localparam int SETTLE      = 100;

  typedef struct {
    func_t                func;
    logic [COL_W-1:0]     idx;
    logic [SAMPLE_W-1:0]  smp;
    bit                   typed;
    result_t              span;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  // predictor state
  int          wave_mem [SAMPLE_COUNT];
  int          peak_mag;
  longint      prev_row;
  logic [10:0] width_reg;

  result_t     span_q [$];
  int          fail_cnt;
  int          req_cnt;
  int          cycle_cnt;
  int          in_gap_pct;
  int          out_stall_pct;

  logic [10:0] corner_widths [6] = '{11'd0, 11'd2047, 11'd1, 11'd1024, 11'd2, 11'd1025};

  dir_row_t dir_rows [25] = '{
    '{FUNC_DRAW,  10'd0,    16'h0000, 1'b1, '{column: 10'd0, top_row: 4'd8, bottom_row: 4'd8}},
    '{FUNC_STORE, 10'd0,    16'h7FFF, 1'b0, '0},
    '{FUNC_DRAW,  10'd0,    16'hFFFF, 1'b1, '{column: 10'd0, top_row: 4'd2, bottom_row: 4'd8}},
    '{FUNC_STORE, 10'd0,    16'h8000, 1'b0, '0},
    '{FUNC_DRAW,  10'd0,    16'h0000, 1'b1, '{column: 10'd0, top_row: 4'd8, bottom_row: 4'd13}},
    '{FUNC_DRAW,  10'd1,    16'h0000, 1'b0, '0},
    '{FUNC_DRAW,  10'd239,  16'h0000, 1'b0, '0},
    '{FUNC_DRAW,  10'd240,  16'h0000, 1'b0, '0},
    '{FUNC_DRAW,  10'd1023, 16'hFFFF, 1'b0, '0},
    '{FUNC_STORE, 10'd128,  16'hFFFF, 1'b0, '0},
    '{FUNC_STORE, 10'd1023, 16'hAAAA, 1'b0, '0},
    '{FUNC_STORE, 10'd127,  16'h5555, 1'b0, '0},
    '{FUNC_DRAW,  10'd239,  16'h0000, 1'b0, '0},
    '{FUNC_STORE, 10'd0,    16'h0000, 1'b0, '0},
    '{FUNC_DRAW,  10'd0,    16'h0000, 1'b1, '{column: 10'd0, top_row: 4'd8, bottom_row: 4'd8}},
    '{FUNC_STORE, 10'd1,    16'h0005, 1'b0, '0},
    '{FUNC_DRAW,  10'd2,    16'h0000, 1'b0, '0},
    '{FUNC_STORE, 10'd2,    16'hFFFD, 1'b0, '0},
    '{FUNC_DRAW,  10'd2,    16'h0000, 1'b0, '0},
    '{FUNC_STORE, 10'd3,    16'h0014, 1'b0, '0},
    '{FUNC_DRAW,  10'd3,    16'h0000, 1'b0, '0},
    '{FUNC_STORE, 10'd4,    16'h006D, 1'b0, '0},
    '{FUNC_STORE, 10'd5,    16'hFF92, 1'b0, '0},
    '{FUNC_DRAW,  10'd4,    16'h0000, 1'b0, '0},
    '{FUNC_DRAW,  10'd5,    16'h0000, 1'b0, '0}
  };

  autogain_scope_trace_renderer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [9:0] index, [25:10] sample
    .in_tuser   (in_tuser),    // [0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [9:0] column, [13:10] top_row, [17:14] bottom_row
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int eff_width(input logic [10:0] v);
    if (v < WIDTH_MIN) return WIDTH_MIN;
    if (v > WIDTH_MAX) return WIDTH_MAX;
    return int'(v);
  endfunction

  // updates the predictor state and returns 1 when the request yields a span
  function automatic bit trace_span(input func_t f, input logic [COL_W-1:0] idx,
                                    input logic [SAMPLE_W-1:0] smp, output result_t span);
    longint w, gain, pos, frac, s0, s1, smooth, row, top, bot;
    int     mag, si, ni;
    span = '0;
    if (f == FUNC_STORE) begin
      if (idx >= SAMPLE_COUNT) return 1'b0;
      mag = int'($signed(smp));
      if (mag < 0) mag = -mag;
      wave_mem[idx] = int'($signed(smp));
      if (idx == 0) peak_mag = 1;
      if (mag > peak_mag) peak_mag = mag;
      return 1'b0;
    end
    w = longint'(eff_width(width_reg));
    if (longint'(idx) >= w) return 1'b0;
    if (idx == 0) prev_row = longint'(MID_ROW);
    gain = longint'((peak_mag < GAIN_LIMIT) ? GAIN_NUM / peak_mag : GAIN_FLAT);
    if (gain > GAIN_CAP) gain = GAIN_CAP;
    pos = (longint'(idx) * (SAMPLE_COUNT - 1) * (1 << FRAC_W)) / (w - 1);
    si = int'(pos / (1 << FRAC_W));
    if (si > SAMPLE_COUNT - 1) si = SAMPLE_COUNT - 1;
    frac = pos - longint'(si) * (1 << FRAC_W);
    ni = si + 1;
    if (ni > SAMPLE_COUNT - 1) ni = SAMPLE_COUNT - 1;
    s0 = longint'(wave_mem[si]);
    s1 = longint'(wave_mem[ni]);
    smooth = s0 + ((s1 - s0) * frac) / (1 << FRAC_W);
    row = MID_ROW - (smooth * gain * (MID_ROW - ROW_MIN)) / FULL_SCALE;
    if (row < ROW_MIN) row = ROW_MIN;
    if (row > ROW_MAX) row = ROW_MAX;
    top = (row < prev_row) ? row : prev_row;
    bot = (row > prev_row) ? row : prev_row;
    span.column     = idx;
    span.top_row    = top[ROW_W-1:0];
    span.bottom_row = bot[ROW_W-1:0];
    prev_row = row;
    return 1'b1;
  endfunction

  task automatic send_req(input func_t f, input logic [COL_W-1:0] idx,
                          input logic [SAMPLE_W-1:0] smp, input bit typed,
                          input result_t typed_span);
    result_t span;
    bit      has;
    in_gap_pct    = (req_cnt < 350) ? 34 : (req_cnt < 700) ? 71 : 0;
    out_stall_pct = (req_cnt < 350) ? 71 : (req_cnt < 700) ? 34 : 0;
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {6'd0, smp, idx};
    do @(posedge clk); while (!in_tready);
    has = trace_span(f, idx, smp, span);
    if (has) span_q.push_back(typed ? typed_span : span);
    req_cnt++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (span_q.size() != 0);
  endtask

  task automatic write_width(input logic [10:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = v;
  endtask

  // full waveform from index 0 upward, amplitude picked per load
  task automatic load_wave();
    int amp, s;
    case ($urandom_range(0, 3))
      0:       amp = $urandom_range(1, 8);
      1:       amp = $urandom_range(9, 130);
      2:       amp = $urandom_range(131, 3000);
      default: amp = 32768;
    endcase
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_req(FUNC_STORE, 10'($urandom_range(SAMPLE_COUNT, 1023)), 16'($urandom),
                 1'b0, '0);
      if (amp == 32768) s = int'($urandom);
      else s = int'($urandom_range(0, 2 * amp)) - amp;
      send_req(FUNC_STORE, 10'(i), s[15:0], 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("autogain_scope_trace_renderer_core_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[17:0];
      if (span_q.size() == 0) begin
        $display("%0t: unexpected span, column %0d top %0d bottom %0d",
                 $time, got.column, got.top_row, got.bottom_row);
        fail_cnt++;
      end else begin
        want = span_q.pop_front();
        if (got.column !== want.column) begin
          $display("%0t: column expected %0d got %0d", $time, want.column, got.column);
          fail_cnt++;
        end
        if (got.top_row !== want.top_row) begin
          $display("%0t: top_row expected %0d got %0d", $time, want.top_row, got.top_row);
          fail_cnt++;
        end
        if (got.bottom_row !== want.bottom_row) begin
          $display("%0t: bottom_row expected %0d got %0d",
                   $time, want.bottom_row, got.bottom_row);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int          phase;
    int          w_eff;
    int          sweep;
    int          c;
    int          pick;
    logic [10:0] w;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= FUNC_STORE;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    cycle_cnt     = 0;
    fail_cnt      = 0;
    req_cnt       = 0;
    in_gap_pct    = 34;
    out_stall_pct = 71;
    peak_mag      = 1;
    prev_row      = longint'(MID_ROW);
    width_reg     = WIDTH_RESET;
    foreach (wave_mem[i]) wave_mem[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero waveform, then the directed rows at the reset width
    for (int i = 0; i < SAMPLE_COUNT; i++)
      send_req(FUNC_STORE, 10'(i), 16'h0000, 1'b0, '0);
    foreach (dir_rows[i])
      send_req(dir_rows[i].func, dir_rows[i].idx, dir_rows[i].smp,
               dir_rows[i].typed, dir_rows[i].span);

    phase = 0;
    while (req_cnt < REQ_TARGET) begin
      if (phase < 6) begin
        w = corner_widths[phase];
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) w = 11'($urandom_range(2, 40));
        else if (pick < 9) w = 11'($urandom_range(41, 300));
        else w = 11'($urandom_range(0, 2047));
      end
      write_width(w);
      if (phase == 0 || $urandom_range(0, 2) == 0) load_wave();
      w_eff = eff_width(w);
      sweep = (w_eff < 48) ? w_eff : 48;
      for (c = 0; c < sweep; c++) begin
        if ($urandom_range(0, 15) == 0)
          send_req(FUNC_STORE, 10'($urandom_range(0, 1023)), 16'($urandom), 1'b0, '0);
        if ($urandom_range(0, 39) == 0) wait_drained();
        send_req(FUNC_DRAW, 10'(c), 16'($urandom), 1'b0, '0);
      end
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 3) == 0) c = $urandom_range(0, 1023);
        else c = $urandom_range(0, w_eff - 1);
        send_req(FUNC_DRAW, 10'(c), 16'($urandom), 1'b0, '0);
      end
      send_req(FUNC_DRAW, 10'(w_eff - 1), 16'($urandom), 1'b0, '0);
      if (w_eff < WIDTH_MAX)
        send_req(FUNC_DRAW, 10'(w_eff), 16'($urandom), 1'b0, '0);
      phase++;
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && span_q.size() == 0) begin
      $display("autogain_scope_trace_renderer_core_tb: PASS");
    end else begin
      $display("autogain_scope_trace_renderer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
